@@ src/nbfa_pkg.sv @@
package nbfa_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [0:0] reg_index_t;
  typedef logic [16:0] level_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_ADD   = 2'd1;
  localparam mode_t MODE_STEP  = 2'd2;
  localparam mode_t MODE_CLEAR = 2'd3;

  localparam reg_index_t REG_GRAV = 1'b0;
  localparam reg_index_t REG_STEP = 1'b1;

  localparam logic [15:0] RED_GAIN  = 16'd9830;
  localparam level_t      LEVEL_ONE = 17'd65536;

endpackage

@@ src/nbfa_if.sv @@
interface nbfa_body_if #(parameter int WORD_BITS = 48);
  logic                        valid;
  logic                        ready;
  nbfa_pkg::mode_t             mode;
  logic signed [WORD_BITS-1:0] pos_x;
  logic signed [WORD_BITS-1:0] pos_y;
  logic signed [WORD_BITS-1:0] pos_z;
  logic signed [WORD_BITS-1:0] vel_x;
  logic signed [WORD_BITS-1:0] vel_y;
  logic signed [WORD_BITS-1:0] vel_z;
  logic        [WORD_BITS-1:0] body_mass;
  modport source(output valid, mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass,
                 input ready);
  modport sink(input valid, mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass,
               output ready);
endinterface

interface nbfa_state_if #(parameter int WORD_BITS = 48);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] new_pos_x;
  logic signed [WORD_BITS-1:0] new_pos_y;
  logic signed [WORD_BITS-1:0] new_pos_z;
  logic signed [WORD_BITS-1:0] new_vel_x;
  logic signed [WORD_BITS-1:0] new_vel_y;
  logic signed [WORD_BITS-1:0] new_vel_z;
  nbfa_pkg::level_t            red_level;
  nbfa_pkg::level_t            blue_level;
  modport source(output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                 new_vel_z, red_level, blue_level, input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, red_level, blue_level, output ready);
endinterface

@@ src/nbody_force_accumulate_and_step_unit.sv @@
// Force accumulation and Euler step for one target body.
// The body channel carries one word per command. A load word sets the target's
// position, velocity and mass and clears the force; a clear word clears the
// force only. An add word brings a source body, whose softened gravity is
// added to the force; most of its work goes to the bit-serial divider (64
// plus FRAC_BITS steps) and the bit-pair square root, with each product formed
// on the 32 by 32 multiplier. A step word integrates velocity and then
// position and sends one word on the result channel; most of its work is
// three divisions. The body channel is ready only while the sequencer is
// idle, one word at a time. The result word sits in an output register until
// the receiver takes it; a further step waits at its end while that register
// is still full, and then returns to idle. Configuration writes are registered
// and are meant for idle periods. Reset returns the target state and force to
// zero, G to one and dt to about 0.01, and empties the output register.
module nbody_force_accumulate_and_step_unit #(
  parameter int FRAC_BITS = 24,
  parameter int WORD_BITS = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  nbfa_pkg::reg_index_t     cfg_index,
  input  logic [WORD_BITS-1:0]     cfg_data,
  nbfa_body_if.sink                body,
  nbfa_state_if.source             result
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  localparam logic [63:0] EPS_RAW = ((64'd1 << F) + 64'd500) / 64'd1000;
  localparam logic [63:0] EPS = (EPS_RAW == 64'd0) ? 64'd1 : EPS_RAW;
  localparam logic signed [63:0] WMAX = signed'(64'((65'd1 << (W - 1)) - 65'd1));
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_ROOT  = 4'd2;
  localparam logic [3:0] ST_D2    = 4'd3;
  localparam logic [3:0] ST_D3    = 4'd4;
  localparam logic [3:0] ST_G1    = 4'd5;
  localparam logic [3:0] ST_G2    = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_FRC   = 4'd8;
  localparam logic [3:0] ST_NUM   = 4'd9;
  localparam logic [3:0] ST_DV    = 4'd10;
  localparam logic [3:0] ST_DP    = 4'd11;
  localparam logic [3:0] ST_VSQ   = 4'd12;
  localparam logic [3:0] ST_ROOT2 = 4'd13;
  localparam logic [3:0] ST_RED   = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t[64] != t[63]) return t[64] ? SMIN : SMAX;
    return t[63:0];
  endfunction

  function automatic logic [63:0] sat_uadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[64] ? '1 : t[63:0];
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    logic signed [63:0] v;
    v = m[63] ? SMAX : signed'(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [W-1:0] clamp_word(input logic signed [63:0] x);
    if (x > WMAX) return W'(WMAX);
    if (x < WMIN) return W'(WMIN);
    return W'(x);
  endfunction

  logic [3:0]            state;
  logic                  launched;
  logic [1:0]            k;
  logic [W-1:0]          grav, dt;
  logic signed [W-1:0]   tpos [3];
  logic signed [W-1:0]   tvel [3];
  logic [W-1:0]          tmass, smass;
  logic signed [63:0]    force_sum [3];
  logic signed [63:0]    diff [3];
  logic [63:0]           acc, fval;
  logic signed [63:0]    p [3];

  logic        mul_start, div_start, sqrt_start;
  logic [63:0] mul_a, mul_b, div_num, div_den;
  logic        mul_done, div_done, sqrt_done, unit_done;
  logic [63:0] mul_res, div_res, sqrt_res;

  nbfa_mul #(.SH(F)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  nbfa_div #(.SH(F)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .res(div_res)
  );

  nbfa_sqrt #(.SH(F)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .s(acc),
    .done(sqrt_done), .res(sqrt_res)
  );

  assign unit_done  = mul_done | div_done | sqrt_done;
  assign body.ready = state == ST_IDLE;

  always_comb begin
    p[0] = 64'(body.pos_x);
    p[1] = 64'(body.pos_y);
    p[2] = 64'(body.pos_z);
  end

  always_comb begin
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = acc;
    mul_b      = acc;
    div_num    = fval;
    div_den    = acc;
    case (state)
      ST_SQ: begin
        mul_start = !launched;
        mul_a     = mag(diff[k]);
        mul_b     = mag(diff[k]);
      end
      ST_VSQ: begin
        mul_start = !launched;
        mul_a     = mag(64'(tvel[k]));
        mul_b     = mag(64'(tvel[k]));
      end
      ST_ROOT, ST_ROOT2: sqrt_start = !launched;
      ST_D2: mul_start = !launched;
      ST_D3: begin
        mul_start = !launched;
        mul_a     = fval;
      end
      ST_G1: begin
        mul_start = !launched;
        mul_a     = 64'(grav);
        mul_b     = 64'(tmass);
      end
      ST_G2: begin
        mul_start = !launched;
        mul_a     = fval;
        mul_b     = 64'(smass);
      end
      ST_DIV: div_start = !launched;
      ST_FRC: begin
        mul_start = !launched;
        mul_a     = fval;
        mul_b     = mag(diff[k]);
      end
      ST_NUM: begin
        mul_start = !launched;
        mul_a     = mag(force_sum[k]);
        mul_b     = 64'(dt);
      end
      ST_DV: begin
        div_start = !launched;
        div_num   = acc;
        div_den   = 64'(tmass);
      end
      ST_DP: begin
        mul_start = !launched;
        mul_a     = mag(64'(tvel[k]));
        mul_b     = 64'(dt);
      end
      ST_RED: begin
        mul_start = !launched;
        mul_b     = 64'(nbfa_pkg::RED_GAIN);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grav  <= W'(64'd1 << F);
      dt    <= W'(64'd167772);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nbfa_pkg::REG_GRAV: grav <= cfg_data;
        nbfa_pkg::REG_STEP: dt   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      k            <= 2'd0;
      tmass        <= '0;
      result.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tpos[i]      <= '0;
        tvel[i]      <= '0;
        force_sum[i] <= '0;
      end
    end else begin
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;
      if (state != ST_IDLE && state != ST_OUT && !launched) launched <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (body.valid) begin
            k   <= 2'd0;
            acc <= '0;
            unique case (body.mode)
              nbfa_pkg::MODE_LOAD: begin
                tpos[0] <= body.pos_x;
                tpos[1] <= body.pos_y;
                tpos[2] <= body.pos_z;
                tvel[0] <= body.vel_x;
                tvel[1] <= body.vel_y;
                tvel[2] <= body.vel_z;
                tmass   <= body.body_mass;
                for (int i = 0; i < 3; i++) force_sum[i] <= '0;
              end
              nbfa_pkg::MODE_CLEAR: begin
                for (int i = 0; i < 3; i++) force_sum[i] <= '0;
              end
              nbfa_pkg::MODE_ADD: begin
                for (int i = 0; i < 3; i++) diff[i] <= sat_add(p[i], -64'(tpos[i]));
                smass <= body.body_mass;
                state <= ST_SQ;
              end
              nbfa_pkg::MODE_STEP: state <= ST_NUM;
              default: ;
            endcase
          end
        end
        ST_SQ, ST_VSQ: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            acc      <= sat_uadd(acc, mul_res);
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= (state == ST_SQ) ? ST_ROOT : ST_ROOT2;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        ST_ROOT, ST_ROOT2: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            acc      <= sqrt_res;
            state    <= (state == ST_ROOT) ? ST_D2 : ST_RED;
          end
        end
        ST_D2: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            fval     <= mul_res;
            state    <= ST_D3;
          end
        end
        ST_D3: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            acc      <= sat_uadd(mul_res, EPS);
            state    <= ST_G1;
          end
        end
        ST_G1, ST_G2: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            fval     <= mul_res;
            state    <= (state == ST_G1) ? ST_G2 : ST_DIV;
          end
        end
        ST_DIV: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            fval     <= div_res;
            k        <= 2'd0;
            state    <= ST_FRC;
          end
        end
        ST_FRC: begin
          if (launched && unit_done) begin
            launched     <= 1'b0;
            force_sum[k] <= sat_add(force_sum[k], from_mag(diff[k][63], mul_res));
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= ST_IDLE;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        ST_NUM: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            acc      <= mul_res;
            state    <= ST_DV;
          end
        end
        ST_DV: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            tvel[k]  <= clamp_word(sat_add(64'(tvel[k]),
                                           from_mag(force_sum[k][63], div_res)));
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= ST_DP;
            end else begin
              k     <= k + 2'd1;
              state <= ST_NUM;
            end
          end
        end
        ST_DP: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            tpos[k]  <= clamp_word(sat_add(64'(tpos[k]), from_mag(tvel[k][W-1], mul_res)));
            if (k == 2'd2) begin
              k     <= 2'd0;
              acc   <= '0;
              state <= ST_VSQ;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        ST_RED: begin
          if (launched && unit_done) begin
            launched <= 1'b0;
            fval     <= mul_res;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid     <= 1'b1;
            result.new_pos_x <= tpos[0];
            result.new_pos_y <= tpos[1];
            result.new_pos_z <= tpos[2];
            result.new_vel_x <= tvel[0];
            result.new_vel_y <= tvel[1];
            result.new_vel_z <= tvel[2];
            if (fval > 64'(nbfa_pkg::LEVEL_ONE)) begin
              result.red_level  <= nbfa_pkg::LEVEL_ONE;
              result.blue_level <= '0;
            end else begin
              result.red_level  <= fval[16:0];
              result.blue_level <= nbfa_pkg::LEVEL_ONE - fval[16:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/nbfa_mul.sv @@
module nbfa_mul #(
  parameter int SH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc;
  logic [1:0]   step;
  logic         busy, pv;
  logic [31:0]  pa, pb;
  logic [63:0]  pp, pp_r;
  logic [6:0]   sh_r;

  assign pa = step[0] ? a_r[63:32] : a_r[31:0];
  assign pb = step[1] ? b_r[63:32] : b_r[31:0];
  assign pp = 64'(pa) * 64'(pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        acc  <= '0;
        step <= 2'd0;
        busy <= 1'b1;
        pv   <= 1'b0;
      end else begin
        if (busy) begin
          pp_r <= pp;
          sh_r <= {step[0] & step[1], step[0] ^ step[1], 5'd0};
          pv   <= 1'b1;
          step <= step + 2'd1;
          if (step == 2'd3) busy <= 1'b0;
        end else begin
          pv <= 1'b0;
        end
        if (pv) acc <= acc + ({64'd0, pp_r} << sh_r);
        done <= pv && !busy;
      end
    end
  end

  assign res = (|acc[127:64+SH]) ? '1 : acc[63+SH:SH];

endmodule

@@ src/nbfa_div.sv @@
module nbfa_div #(
  parameter int SH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] res
);

  localparam int N  = 64 + SH;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dvd;
  logic [63:0]   den_r, rem, q;
  logic          over, zden, numnz, busy;
  logic [CW-1:0] cnt;
  logic [64:0]   remsh;
  logic          ge;

  assign remsh = {rem, dvd[N-1]};
  assign ge    = remsh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd   <= {num, {SH{1'b0}}};
        den_r <= den;
        rem   <= '0;
        q     <= '0;
        over  <= 1'b0;
        zden  <= den == 64'd0;
        numnz <= num != 64'd0;
        cnt   <= CW'(N);
        busy  <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 64'(remsh - {1'b0, den_r}) : 64'(remsh);
        dvd  <= dvd << 1;
        q    <= {q[62:0], ge};
        over <= over | q[63];
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = zden ? (numnz ? '1 : '0) : (over ? '1 : q);

endmodule

@@ src/nbfa_sqrt.sv @@
module nbfa_sqrt #(
  parameter int SH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] s,
  output logic        done,
  output logic [63:0] res
);

  localparam int ITER = (64 + SH + 1) / 2;
  localparam int NB   = 2 * ITER;
  localparam int RW   = ITER + 2;
  localparam int CW   = $clog2(ITER + 1);

  logic [NB-1:0]   nsr;
  logic [RW-1:0]   rem;
  logic [ITER-1:0] root;
  logic [CW-1:0]   cnt;
  logic            busy, ge;
  logic [RW+1:0]   remsh, trial;

  assign remsh = {rem, nsr[NB-1:NB-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = remsh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsr  <= NB'({s, {SH{1'b0}}});
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(ITER);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? RW'(remsh - trial) : RW'(remsh);
        root <= {root[ITER-2:0], ge};
        nsr  <= nsr << 2;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = 64'(root);

endmodule

@@ tb/sv/nbody_force_accumulate_and_step_unit_tb.sv @@
module nbody_force_accumulate_and_step_unit_tb;
  import nbfa_pkg::*;

  localparam int FRAC = 24;
  localparam int WB = 48;
  localparam int QUIET_CYCLES = 450;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [63:0] EPS_CUBE = ((64'd1 << FRAC) + 64'd500) / 64'd1000;
  localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (WB - 1)) - 64'sd1;
  localparam logic signed [63:0] WORD_MIN = -(64'sd1 <<< (WB - 1));
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [WB-1:0] P_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] P_MIN = {1'b1, {(WB-1){1'b0}}};

  typedef struct packed {
    mode_t                mode;
    logic signed [WB-1:0] px, py, pz, vx, vy, vz;
    logic [WB-1:0]        mass;
  } body_word_t;

  typedef struct packed {
    logic signed [WB-1:0] px, py, pz, vx, vy, vz;
    level_t               red, blue;
  } state_word_t;

  typedef struct {
    body_word_t  w;
    bit          typed;
    state_word_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  reg_index_t cfg_index;
  logic [WB-1:0] cfg_data;

  nbfa_body_if #(.WORD_BITS(WB)) body_ch ();
  nbfa_state_if #(.WORD_BITS(WB)) result_ch ();

  nbody_force_accumulate_and_step_unit #(.FRAC_BITS(FRAC), .WORD_BITS(WB)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .body(body_ch), .result(result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block's state.
  logic [63:0] grav_g, step_dt, tgt_mass;
  logic signed [63:0] tgt_pos [3];
  logic signed [63:0] tgt_vel [3];
  logic signed [63:0] force_acc [3];

  state_word_t pending_states [$];
  int mismatches = 0;
  int words_sent = 0;
  int states_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_count = 0;
  table_row_t rows [$];

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] div_shift(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return (num != 0) ? '1 : 64'd0;
    q = ({64'd0, num} << FRAC) / {64'd0, den};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, S64_MAX})) return S64_MAX;
    if (s < $signed({1'b1, S64_MIN})) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic signed [63:0] signed_of(bit neg, logic [63:0] m);
    logic signed [63:0] v;
    v = (m > S64_MAX) ? S64_MAX : $signed(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [63:0] word_clamp(logic signed [63:0] x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic logic [63:0] vec_length(logic signed [63:0] a, logic signed [63:0] b,
                                             logic signed [63:0] c);
    logic [64:0] s;
    logic [127:0] n, cc;
    logic [63:0] r, t;
    s = 0;
    s = s + mul_shift(magnitude(a), magnitude(a), FRAC);
    s = s + mul_shift(magnitude(b), magnitude(b), FRAC);
    if (s[64]) s = {1'b0, {64{1'b1}}};
    s = s + mul_shift(magnitude(c), magnitude(c), FRAC);
    if (s[64]) s = {1'b0, {64{1'b1}}};
    n = {64'd0, s[63:0]} << FRAC;
    r = 0;
    for (int b2 = 63; b2 >= 0; b2--) begin
      t = r | (64'd1 << b2);
      cc = {64'd0, t} * {64'd0, t};
      if (cc <= n) r = t;
    end
    return r;
  endfunction

  function automatic bit predict_body(body_word_t w, output state_word_t o);
    logic signed [63:0] p [3];
    logic signed [63:0] diff [3];
    logic [63:0] d, den, gmm, f, c, speed, red;
    o = '0;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    case (w.mode)
      MODE_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          tgt_pos[k] = p[k];
          force_acc[k] = 0;
        end
        tgt_vel[0] = w.vx; tgt_vel[1] = w.vy; tgt_vel[2] = w.vz;
        tgt_mass = w.mass;
        return 0;
      end
      MODE_CLEAR: begin
        for (int k = 0; k < 3; k++) force_acc[k] = 0;
        return 0;
      end
      MODE_ADD: begin
        for (int k = 0; k < 3; k++) diff[k] = add_sat(p[k], -tgt_pos[k]);
        d = vec_length(diff[0], diff[1], diff[2]);
        d = mul_shift(mul_shift(d, d, FRAC), d, FRAC);
        den = (d > ~EPS_CUBE) ? '1 : d + EPS_CUBE;
        gmm = mul_shift(mul_shift(grav_g, tgt_mass, FRAC), {16'd0, w.mass}, FRAC);
        f = div_shift(gmm, den);
        for (int k = 0; k < 3; k++) begin
          c = mul_shift(f, magnitude(diff[k]), FRAC);
          force_acc[k] = add_sat(force_acc[k], signed_of(diff[k][63], c));
        end
        return 0;
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          c = div_shift(mul_shift(magnitude(force_acc[k]), step_dt, FRAC), tgt_mass);
          tgt_vel[k] = word_clamp(add_sat(tgt_vel[k], signed_of(force_acc[k][63], c)));
        end
        for (int k = 0; k < 3; k++) begin
          c = mul_shift(magnitude(tgt_vel[k]), step_dt, FRAC);
          tgt_pos[k] = word_clamp(add_sat(tgt_pos[k], signed_of(tgt_vel[k][63], c)));
        end
        speed = vec_length(tgt_vel[0], tgt_vel[1], tgt_vel[2]);
        red = mul_shift(speed, {48'd0, RED_GAIN}, FRAC);
        if (red > LEVEL_ONE) red = LEVEL_ONE;
        o.px = tgt_pos[0][WB-1:0]; o.py = tgt_pos[1][WB-1:0]; o.pz = tgt_pos[2][WB-1:0];
        o.vx = tgt_vel[0][WB-1:0]; o.vy = tgt_vel[1][WB-1:0]; o.vz = tgt_vel[2][WB-1:0];
        o.red = red[16:0];
        o.blue = LEVEL_ONE - red[16:0];
        return 1;
      end
    endcase
  endfunction

  function automatic logic signed [WB-1:0] rand_coord();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 3) return r[WB-1:0];
    return $signed(r[31:0]);
  endfunction

  function automatic body_word_t rand_body(mode_t m);
    body_word_t w;
    logic [63:0] r;
    w.mode = m;
    w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
    w.vx = rand_coord(); w.vy = rand_coord(); w.vz = rand_coord();
    r = {$urandom, $urandom};
    w.mass = ($urandom_range(0, 9) < 3) ? r[WB-1:0] : {16'd0, r[31:0]};
    return w;
  endfunction

  task automatic send_body(body_word_t w, bit typed, state_word_t want);
    state_word_t o;
    while ($urandom_range(0, 99) < send_idle) begin
      body_ch.valid <= 1'b0;
      @(posedge clk);
    end
    body_ch.valid <= 1'b1;
    body_ch.mode <= w.mode;
    body_ch.pos_x <= w.px; body_ch.pos_y <= w.py; body_ch.pos_z <= w.pz;
    body_ch.vel_x <= w.vx; body_ch.vel_y <= w.vy; body_ch.vel_z <= w.vz;
    body_ch.body_mass <= w.mass;
    do @(posedge clk); while (!body_ch.ready);
    words_sent++;
    if (predict_body(w, o)) pending_states.push_back(typed ? want : o);
  endtask

  task automatic write_config(logic [WB-1:0] g, logic [WB-1:0] dt);
    body_ch.valid <= 1'b0;
    wait (pending_states.size() == 0);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_GRAV; cfg_data <= g;
    @(posedge clk);
    cfg_index <= REG_STEP; cfg_data <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    grav_g = {16'd0, g};
    step_dt = {16'd0, dt};
  endtask

  task automatic add_row(mode_t m, logic signed [WB-1:0] p, logic signed [WB-1:0] v,
                         logic [WB-1:0] mass, bit typed, state_word_t want);
    table_row_t r;
    r.w = '{m, p, p, p, v, v, v, mass};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served < hold_requests) begin
      result_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    state_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      states_seen++;
      if (pending_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = pending_states.pop_front();
        if (result_ch.new_pos_x !== want.px || result_ch.new_pos_y !== want.py ||
            result_ch.new_pos_z !== want.pz || result_ch.new_vel_x !== want.vx ||
            result_ch.new_vel_y !== want.vy || result_ch.new_vel_z !== want.vz ||
            result_ch.red_level !== want.red || result_ch.blue_level !== want.blue) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result word %0d", states_seen);
            $display("  expected pos %h %h %h vel %h %h %h red %h blue %h", want.px, want.py,
                     want.pz, want.vx, want.vy, want.vz, want.red, want.blue);
            $display("  actual   pos %h %h %h vel %h %h %h red %h blue %h",
                     result_ch.new_pos_x, result_ch.new_pos_y, result_ch.new_pos_z,
                     result_ch.new_vel_x, result_ch.new_vel_y, result_ch.new_vel_z,
                     result_ch.red_level, result_ch.blue_level);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (body_ch.valid && body_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    state_word_t none, zero_state, max_state, min_state;
    body_word_t w;
    int reps;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_GRAV; cfg_data = '0;
    body_ch.valid = 1'b0; body_ch.mode = MODE_LOAD;
    body_ch.pos_x = '0; body_ch.pos_y = '0; body_ch.pos_z = '0;
    body_ch.vel_x = '0; body_ch.vel_y = '0; body_ch.vel_z = '0; body_ch.body_mass = '0;
    grav_g = 64'd1 << FRAC; step_dt = 64'd167772; tgt_mass = 0;
    for (int k = 0; k < 3; k++) begin
      tgt_pos[k] = 0; tgt_vel[k] = 0; force_acc[k] = 0;
    end
    none = '0;
    zero_state = '0; zero_state.blue = LEVEL_ONE;
    max_state = '{P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, LEVEL_ONE, 17'd0};
    min_state = '{P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, LEVEL_ONE, 17'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle = 33; recv_idle = 60;
    add_row(MODE_STEP, 0, 0, 0, 1, zero_state);
    add_row(MODE_LOAD, P_MAX, P_MAX, 0, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 1, max_state);
    add_row(MODE_LOAD, P_MIN, P_MIN, '1, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 1, min_state);
    add_row(MODE_LOAD, 0, 0, 48'd1 << FRAC, 0, none);
    add_row(MODE_ADD, 0, 0, 48'd1 << FRAC, 0, none);
    add_row(MODE_ADD, 48'sd1 << FRAC, 0, 48'd5 << FRAC, 0, none);
    add_row(MODE_ADD, P_MIN, P_MAX, '1, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 0, none);
    add_row(MODE_CLEAR, P_MAX, P_MIN, '1, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 0, none);
    add_row(MODE_LOAD, 48'sd3 << FRAC, -(48'sd2 << FRAC), 0, 0, none);
    add_row(MODE_ADD, -(48'sd1 << FRAC), 48'sd7, 48'd2 << FRAC, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 0, none);
    add_row(MODE_ADD, P_MAX, 0, 48'd9 << FRAC, 0, none);
    add_row(MODE_STEP, 0, 0, 0, 0, none);
    foreach (rows[i]) send_body(rows[i].w, rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_config(48'd1 << FRAC, 48'd167772);
        1: write_config('1, '0);
        2: write_config('0, '1);
        default: write_config({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      case (phase % 3)
        0: begin send_idle = 33; recv_idle = 60; end
        1: begin send_idle = 60; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 1) hold_requests = hold_requests + 1;
      reps = 0;
      while (reps < 150) begin
        if ($urandom_range(0, 9) == 0) begin
          w = rand_body(mode_t'($urandom_range(0, 3)));
          send_body(w, 0, none);
          reps++;
        end else begin
          send_body(rand_body(MODE_LOAD), 0, none);
          for (int j = $urandom_range(0, 4); j > 0; j--) send_body(rand_body(MODE_ADD), 0, none);
          if ($urandom_range(0, 9) == 0) send_body(rand_body(MODE_CLEAR), 0, none);
          send_body(rand_body(MODE_STEP), 0, none);
          if ($urandom_range(0, 3) == 0) send_body(rand_body(MODE_STEP), 0, none);
          reps += 4;
        end
      end
    end
    body_ch.valid <= 1'b0;
    wait (pending_states.size() == 0);
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("sent %0d body words over four register settings and three idling patterns",
             words_sent);
    $display("checked %0d result words, %0d mismatches", states_seen, mismatches);
    if (mismatches == 0 && pending_states.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
